@@ rtl/plg_pkg.sv @@
package plg_pkg;

    localparam int X_WIDTH   = 32;
    localparam int LOG_WIDTH = 21;

    localparam int DEF_INT_BITS  = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int POS_WIDTH = $clog2(X_WIDTH);

endpackage

@@ rtl/plg_if.sv @@
interface plg_in_if;
    logic                         valid;
    logic                         ready;
    logic [plg_pkg::X_WIDTH-1:0]  x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface plg_out_if;
    logic                          valid;
    logic                          ready;
    logic [plg_pkg::LOG_WIDTH-1:0] log_value;
    logic                          at_or_below_one;

    modport source (output valid, output log_value, output at_or_below_one, input ready);
    modport sink   (input valid, input log_value, input at_or_below_one, output ready);
endinterface

@@ rtl/plg_lod.sv @@
module plg_lod #(
    parameter int INT_BITS  = plg_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS = plg_pkg::DEF_FRAC_BITS,
    parameter int EXP_W     = 5
) (
    input  logic [plg_pkg::X_WIDTH-1:0] i_x,
    output logic                        o_below,
    output logic [EXP_W-1:0]            o_exp,
    output logic [FRAC_BITS-1:0]        o_mant
);

    localparam int XW   = plg_pkg::X_WIDTH;
    localparam int PW   = plg_pkg::POS_WIDTH;
    localparam int IN_W = INT_BITS + FRAC_BITS;
    localparam logic [XW-1:0] InMask =
        (IN_W >= XW) ? {XW{1'b1}} : XW'((64'd1 << IN_W) - 64'd1);
    localparam logic [XW:0] One = (XW + 1)'(64'd1 << FRAC_BITS);

    logic [XW-1:0] x_m;
    logic [PW-1:0] pos;
    logic [PW:0]   k_full;
    logic [XW-1:0] shifted;

    always_comb begin
        x_m = i_x & InMask;
        pos = '0;
        for (int i = 0; i < XW; i++) begin
            if (x_m[i]) begin
                pos = PW'(i);
            end
        end
        k_full  = {1'b0, pos} - (PW + 1)'(FRAC_BITS);
        shifted = x_m >> k_full;
        o_below = ({1'b0, x_m} <= One);
        o_exp   = EXP_W'(k_full);
        o_mant  = shifted[FRAC_BITS-1:0];
    end

endmodule

@@ rtl/plg_seg.sv @@
module plg_seg #(
    parameter int FRAC_BITS = plg_pkg::DEF_FRAC_BITS,
    parameter int EXP_W     = 5
) (
    input  logic                          i_below,
    input  logic [EXP_W-1:0]              i_exp,
    input  logic [FRAC_BITS-1:0]          i_mant,
    output logic [plg_pkg::LOG_WIDTH-1:0] o_log
);

    localparam int LW = plg_pkg::LOG_WIDTH;
    localparam int CW = (FRAC_BITS + 7 > LW + 1) ? FRAC_BITS + 7 : LW + 1;

    localparam longint One    = 64'd1 << FRAC_BITS;
    localparam longint Quart  = One >> 2;
    localparam longint Half   = One >> 1;
    localparam longint ThreeQ = Quart * 3;
    localparam longint OffB   = (One + 3200) / 6400;
    localparam longint OffC   = One >> 4;
    localparam longint OffD   = One >> 2;
    localparam longint LogMax = (64'd1 << LW) - 64'd1;

    logic [CW-1:0] mx;
    logic [CW-1:0] seg;
    logic [CW-1:0] res;

    always_comb begin
        mx = CW'(i_mant);
        if (mx <= CW'(Quart)) begin
            seg = ((mx << 4) + (mx << 2) + mx) >> 4;
        end else if (mx <= CW'(Half)) begin
            seg = (((mx << 6) + (mx << 2) + mx) >> 6) + CW'(OffB);
        end else if (mx <= CW'(ThreeQ)) begin
            seg = (((mx << 6) + mx) >> 6) + CW'(OffC);
        end else begin
            seg = (((mx << 1) + mx) >> 2) + CW'(OffD);
        end
        res = (CW'(i_exp) << FRAC_BITS) + seg;
        if (i_below) begin
            o_log = '0;
        end else if (res > CW'(LogMax)) begin
            o_log = LW'(LogMax);
        end else begin
            o_log = res[LW-1:0];
        end
    end

endmodule

@@ rtl/piecewise_linear_log2.sv @@
// Approximate base-2 logarithm of an unsigned fixed-point value with INT_BITS
// integer and FRAC_BITS fraction bits: log_value = k + f(m), where k is the
// position of the leading one above the binary point and f is a four-segment
// shift-add fit of the mantissa fraction m; inputs at or below 1.0 give zero
// with at_or_below_one set. Throughput is one item per clock, sustained while
// the output side takes results; each item passes from the input register
// through leading-one detect, normalize and segment logic into the result
// register, which drives the output. Either register holds its item while the
// next stage stalls, so the input keeps accepting until both are full.
module piecewise_linear_log2 #(
    parameter int INT_BITS  = plg_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS = plg_pkg::DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plg_in_if.sink    i_in,
    plg_out_if.source o_out
);

    localparam int XW    = plg_pkg::X_WIDTH;
    localparam int LW    = plg_pkg::LOG_WIDTH;
    localparam int TOP_W = (INT_BITS + FRAC_BITS < XW) ? INT_BITS + FRAC_BITS : XW;
    localparam int K_MAX = TOP_W - FRAC_BITS - 1;
    localparam int EXP_W = (K_MAX <= 1) ? 1 : $clog2(K_MAX + 1);

    logic          r_in_valid;
    logic          n_in_valid;
    logic [XW-1:0] r_x;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [LW-1:0] r_log;
    logic          r_below;

    logic                 adv_out;
    logic                 below;
    logic [EXP_W-1:0]     exp_k;
    logic [FRAC_BITS-1:0] mant;
    logic [LW-1:0]        log_v;

    plg_lod #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS),
        .EXP_W     (EXP_W)
    ) u_lod (
        .i_x     (r_x),
        .o_below (below),
        .o_exp   (exp_k),
        .o_mant  (mant)
    );

    plg_seg #(
        .FRAC_BITS (FRAC_BITS),
        .EXP_W     (EXP_W)
    ) u_seg (
        .i_below (below),
        .i_exp   (exp_k),
        .i_mant  (mant),
        .o_log   (log_v)
    );

    assign adv_out    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv_out;

    assign n_in_valid  = i_in.ready ? i_in.valid : r_in_valid;
    assign n_out_valid = adv_out ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // advance payloads on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x <= i_in.x_value;
        end
        if (adv_out && r_in_valid) begin
            r_log   <= log_v;
            r_below <= below;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.log_value       = r_log;
    assign o_out.at_or_below_one = r_below;

    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("input transfer not captured");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv_out |=> r_out_valid)
        else $error("input stage advanced without a result");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid && !r_out_valid |-> i_in.ready)
        else $error("empty pipeline refuses input");

    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_below |-> r_log == '0)
        else $error("flagged result is not zero");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while both stages stall");

endmodule

@@ sim/piecewise_linear_log2_test.sv @@
module piecewise_linear_log2_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_WIDTH      = plg_pkg::X_WIDTH;
    localparam int LOG_WIDTH    = plg_pkg::LOG_WIDTH;
    localparam int INT_BITS     = plg_pkg::DEF_INT_BITS;
    localparam int FRAC_BITS    = plg_pkg::DEF_FRAC_BITS;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        PH_SINK_STALLS,
        PH_SOURCE_GAPS,
        PH_FULL_RATE
    } t_traffic_phase;

    typedef struct {
        logic [X_WIDTH-1:0] x;
        t_traffic_phase     phase;
    } t_x_item;

    typedef struct {
        logic [LOG_WIDTH-1:0] log_value;
        logic                 at_or_below_one;
    } t_log_result;

    logic i_clk;
    logic i_rst_n;

    plg_in_if  in_bus ();
    plg_out_if out_bus ();

    piecewise_linear_log2 #(
        .INT_BITS (INT_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus.sink),
        .o_out  (out_bus.source)
    );

    t_x_item        pending_items[$];
    t_log_result    expected_logs[$];
    t_traffic_phase drive_phase;
    int             error_count;
    int             cycle_count;

    function automatic t_log_result predict_log2(logic [X_WIDTH-1:0] x_in);
        logic [63:0] x;
        logic [63:0] one;
        logic [63:0] mask;
        logic [63:0] m;
        logic [63:0] seg;
        logic [63:0] res;
        int          lead;
        int          k;
        t_log_result r;
        one  = 64'd1 << FRAC_BITS;
        mask = (INT_BITS + FRAC_BITS >= 32) ? 64'hFFFF_FFFF
                                            : (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;
        x    = {32'd0, x_in} & mask;
        if (x <= one) begin
            r.log_value       = '0;
            r.at_or_below_one = 1'b1;
            return r;
        end
        lead = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                lead = i;
            end
        end
        k = lead - FRAC_BITS;
        m = (x >> k) - one;
        if (m <= (one >> 2)) begin
            seg = (m * 64'd21) >> 4;
        end else if (m <= (one >> 1)) begin
            seg = ((m * 64'd69) >> 6) + ((one + 64'd3200) / 64'd6400);
        end else if (m <= ((one >> 2) * 64'd3)) begin
            seg = ((m * 64'd65) >> 6) + (one >> 4);
        end else begin
            seg = ((m * 64'd3) >> 2) + (one >> 2);
        end
        res = (64'(k) << FRAC_BITS) + seg;
        if (res > (64'd1 << LOG_WIDTH) - 64'd1) begin
            res = (64'd1 << LOG_WIDTH) - 64'd1;
        end
        r.log_value       = res[LOG_WIDTH-1:0];
        r.at_or_below_one = 1'b0;
        return r;
    endfunction

    function automatic int source_idle_pct(t_traffic_phase ph);
        case (ph)
            PH_SINK_STALLS: return 33;
            PH_SOURCE_GAPS: return 68;
            default:        return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct(t_traffic_phase ph);
        case (ph)
            PH_SINK_STALLS: return 68;
            PH_SOURCE_GAPS: return 33;
            default:        return 0;
        endcase
    endfunction

    function automatic logic [X_WIDTH-1:0] random_x();
        logic [X_WIDTH-1:0] v;
        logic [X_WIDTH-1:0] low_mask;
        int                 p;
        int                 k;
        int                 b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: begin
                p        = $urandom_range(FRAC_BITS, X_WIDTH - 1);
                low_mask = (32'd1 << p) - 32'd1;
                v        = (32'd1 << p) | ($urandom & low_mask);
            end
            7: v = $urandom_range(0, 1 << FRAC_BITS);
            8: begin
                k        = $urandom_range(0, INT_BITS - 1);
                b        = $urandom_range(1, 3) * (1 << (FRAC_BITS - 2))
                           + $urandom_range(0, 4) - 2;
                low_mask = (32'd1 << k) - 32'd1;
                v        = (32'((1 << FRAC_BITS) + b) << k) | ($urandom & low_mask);
            end
            default: v = $urandom_range((1 << FRAC_BITS) + 1, (4 << FRAC_BITS) - 1);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
        error_count++;
    endtask

    task automatic queue_x(logic [X_WIDTH-1:0] x, t_traffic_phase ph);
        t_x_item it;
        it.x     = x;
        it.phase = ph;
        pending_items.push_back(it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("piecewise_linear_log2 regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                expected_logs.push_back(predict_log2(in_bus.x_value));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= source_idle_pct(pending_items[0].phase)) begin
                    in_bus.valid   <= 1'b1;
                    in_bus.x_value <= pending_items[0].x;
                    drive_phase    <= pending_items[0].phase;
                    pending_items.pop_front();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_log_result want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_logs.size() == 0) begin
                    report_mismatch("unexpected transfer", out_bus.log_value, 0);
                end else begin
                    want = expected_logs.pop_front();
                    if (out_bus.log_value !== want.log_value) begin
                        report_mismatch("log_value", out_bus.log_value, want.log_value);
                    end
                    if (out_bus.at_or_below_one !== want.at_or_below_one) begin
                        report_mismatch("at_or_below_one", out_bus.at_or_below_one,
                                        want.at_or_below_one);
                    end
                end
            end
            out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct(drive_phase));
        end
    end

    initial begin
        t_traffic_phase ph;
        in_bus.valid   = 1'b0;
        in_bus.x_value = '0;
        out_bus.ready  = 1'b0;
        drive_phase    = PH_SINK_STALLS;
        error_count    = 0;
        cycle_count    = 0;
        i_rst_n        = 1'b0;

        queue_x(32'h0000_0000, PH_SINK_STALLS);
        queue_x(32'h0000_0001, PH_SINK_STALLS);
        queue_x(32'h0000_FFFF, PH_SINK_STALLS);
        queue_x(32'h0001_0000, PH_SINK_STALLS);
        queue_x(32'h0001_0001, PH_SINK_STALLS);
        queue_x(32'h0001_4000, PH_SINK_STALLS);
        queue_x(32'h0001_4001, PH_SINK_STALLS);
        queue_x(32'h0001_8000, PH_SINK_STALLS);
        queue_x(32'h0001_8001, PH_SINK_STALLS);
        queue_x(32'h0001_C000, PH_SINK_STALLS);
        queue_x(32'h0001_C001, PH_SINK_STALLS);
        queue_x(32'h0001_FFFF, PH_SINK_STALLS);
        queue_x(32'h0002_0000, PH_SINK_STALLS);
        queue_x(32'h0002_C001, PH_SINK_STALLS);
        queue_x(32'h0005_7FFF, PH_SINK_STALLS);
        queue_x(32'h0006_0003, PH_SINK_STALLS);
        queue_x(32'h8000_0000, PH_SINK_STALLS);
        queue_x(32'hA000_0000, PH_SINK_STALLS);
        queue_x(32'hC000_0001, PH_SINK_STALLS);
        queue_x(32'hFFFF_FFFF, PH_SINK_STALLS);
        queue_x(32'h5555_5555, PH_SINK_STALLS);
        queue_x(32'hAAAA_AAAA, PH_SINK_STALLS);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i < RANDOM_ITEMS / 3) begin
                ph = PH_SINK_STALLS;
            end else if (i < 2 * RANDOM_ITEMS / 3) begin
                ph = PH_SOURCE_GAPS;
            end else begin
                ph = PH_FULL_RATE;
            end
            queue_x(random_x(), ph);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_items.size() > 0 || in_bus.valid || expected_logs.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_logs.size() > 0 || error_count > 0) begin
            if (expected_logs.size() > 0) begin
                $display("%0d results never arrived", expected_logs.size());
            end
            $display("piecewise_linear_log2 regression: fail");
        end else begin
            $display("piecewise_linear_log2 regression: pass");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/plg_pkg.sv
rtl/plg_if.sv
rtl/plg_lod.sv
rtl/plg_seg.sv
rtl/piecewise_linear_log2.sv
sim/piecewise_linear_log2_test.sv
